// ----- hw/rtl/vtp_pkg.sv -----
`default_nettype none
package vtp_pkg;
    localparam int DivBits = 48;
    localparam logic [63:0] Row0Cols01Rst = 64'h0000_0000_0001_0000;
    localparam logic [63:0] Row1Cols01Rst = 64'h0001_0000_0000_0000;
    localparam logic [63:0] Row2Cols23Rst = 64'h0000_0000_0001_0000;
    localparam logic [63:0] Row3Cols23Rst = 64'h0001_0000_0000_0000;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
        logic signed [66:0] maxv;
        logic signed [66:0] minv;
        maxv = 67'sd2147483647;
        minv = -67'sd2147483648;
        if (v > maxv) begin
            return 32'sh7fffffff;
        end else if (v < minv) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/vtp_div.sv -----
`default_nettype none
// Pipelined restoring divider: one quotient bit per stage, magnitudes only.
// The dividend is (num << 16) with |num| <= 2^31, so 48 bits suffice.
module vtp_div (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic signed [31:0] num,
    input  wire logic signed [31:0] den,
    output logic signed [31:0] quo
);
    import vtp_pkg::*;

    logic [DivBits-1:0] n_reg [DivBits+1];
    logic [DivBits-1:0] q_reg [DivBits+1];
    logic [32:0]        r_reg [DivBits+1];
    logic [31:0]        d_reg [DivBits+1];
    logic               neg_reg [DivBits+1];

    logic [32:0] num_mag;
    logic [32:0] den_mag;
    assign num_mag = num[31] ? 33'(-$signed({num[31], num})) : {1'b0, num};
    assign den_mag = den[31] ? 33'(-$signed({den[31], den})) : {1'b0, den};

    // Stage zero loads the operands.
    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg[0]   <= {num_mag[31:0], 16'h0000};
            q_reg[0]   <= '0;
            r_reg[0]   <= '0;
            d_reg[0]   <= den_mag[31:0];
            neg_reg[0] <= num[31] ^ den[31];
        end
    end

    // Each stage brings down one dividend bit and tries one subtraction.
    for (genvar s = 0; s < DivBits; s++) begin : g_stage
        logic [33:0] trial;
        logic [33:0] rem_sh;
        assign rem_sh = {r_reg[s], n_reg[s][DivBits-1]};
        assign trial  = rem_sh - {2'b00, d_reg[s]};
        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[s+1]   <= {n_reg[s][DivBits-2:0], 1'b0};
                r_reg[s+1]   <= trial[33] ? rem_sh[32:0] : trial[32:0];
                q_reg[s+1]   <= {q_reg[s][DivBits-2:0], ~trial[33]};
                d_reg[s+1]   <= d_reg[s];
                neg_reg[s+1] <= neg_reg[s];
            end
        end
    end

    logic signed [66:0] sq;
    assign sq = neg_reg[DivBits] ? -$signed({19'd0, q_reg[DivBits]})
                                 : $signed({19'd0, q_reg[DivBits]});
    assign quo = sat32(sq);
endmodule
`default_nettype wire

// ----- hw/rtl/vertex_transform_perspective.sv -----
`default_nettype none
// Results pass through the products, sums, saturation, 48 divider stages and the
// output register. Throughput: one vertex per cycle, set by the fully pipelined
// multiply and divide stages; a stall freezes the whole pipe.
// Reset (synchronous, active low) clears all valid bits and loads the identity.
module vertex_transform_perspective (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [63:0]  cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // in_x, in_y, in_z, in_w from bit 0 up
    input  wire logic [127:0] s_tdata,
    // func
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_x, out_y, out_z, out_w from bit 0 up
    output logic [127:0]      m_tdata,
    // w_zero
    output logic              m_tuser
);
    import vtp_pkg::*;

    localparam int Depth = DivBits + 4;

    logic [63:0] mat_reg [8];
    logic        en;
    logic        vld_reg [Depth];

    // Pipeline advances whenever the output slot is free or being taken.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mat_reg[0] <= Row0Cols01Rst;
            mat_reg[1] <= '0;
            mat_reg[2] <= Row1Cols01Rst;
            mat_reg[3] <= '0;
            mat_reg[4] <= '0;
            mat_reg[5] <= Row2Cols23Rst;
            mat_reg[6] <= '0;
            mat_reg[7] <= Row3Cols23Rst;
        end else if (cfg_we) begin
            mat_reg[cfg_index] <= cfg_data;
        end
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < Depth; i++) vld_reg[i] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < Depth; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end
    assign m_tvalid = vld_reg[Depth-1];

    // Stage 1: sixteen 32x32 products.
    logic signed [63:0] prod_reg [4][4];
    logic               fn_reg [Depth];
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    prod_reg[r][c] <= $signed(mat_reg[2*r + c/2][32*(c%2) +: 32])
                                    * $signed(s_tdata[32*c +: 32]);
                end
            end
        end
    end

    // Stage 2: row sums, shift and saturation.
    logic signed [31:0] row_reg [4];
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 4; r++) begin
                row_reg[r] <= sat32(67'((67'(prod_reg[r][0]) + 67'(prod_reg[r][1])
                    + 67'(prod_reg[r][2]) + 67'(prod_reg[r][3])) >>> 16));
            end
        end
    end

    // Function bit and undivided rows ride along the divider.
    logic signed [31:0] dly_reg [DivBits+1][4];
    always_ff @(posedge aclk) begin
        if (en) begin
            fn_reg[0] <= s_tuser;
            for (int i = 1; i < Depth; i++) fn_reg[i] <= fn_reg[i-1];
            for (int r = 0; r < 4; r++) dly_reg[0][r] <= row_reg[r];
            for (int i = 1; i <= DivBits; i++) dly_reg[i] <= dly_reg[i-1];
        end
    end

    // Divider for x, y, z; a zero w divides by one and the result is discarded.
    logic signed [31:0] quo [3];
    logic signed [31:0] den;
    assign den = (row_reg[3] == 32'sd0) ? 32'sd1 : row_reg[3];
    for (genvar k = 0; k < 3; k++) begin : g_div
        vtp_div u_div (
            .aclk (aclk),
            .en   (en),
            .num  (row_reg[k]),
            .den  (den),
            .quo  (quo[k])
        );
    end

    // Output register.
    logic        dfn;
    logic        wz;
    assign dfn = fn_reg[DivBits+2];
    assign wz  = dfn && (dly_reg[DivBits][3] == 32'sd0);
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                m_tdata[32*k +: 32] <= (dfn && !wz) ? quo[k] : dly_reg[DivBits][k];
            end
            m_tdata[127:96] <= dly_reg[DivBits][3];
            m_tuser         <= wz;
        end
    end
endmodule
`default_nettype wire
